// ===== hw/rtl/script_source_lexer_core_macros.svh =====
// Assertion macros for the script source lexer.
// Uses clk and rst_n of the module that includes this header.
`ifndef SCRIPT_SOURCE_LEXER_CORE_MACROS_SVH
`define SCRIPT_SOURCE_LEXER_CORE_MACROS_SVH

// Same-cycle implication.
`define SSL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ssl_pkg.sv =====
// Shared types, codes and byte classification for the script source lexer.
// No dependencies.
package ssl_pkg;

    localparam logic [2:0] MODE_IDLE        = 3'd0;
    localparam logic [2:0] MODE_IDENT       = 3'd1;
    localparam logic [2:0] MODE_STRING      = 3'd2;
    localparam logic [2:0] MODE_NUMBER      = 3'd3;
    localparam logic [2:0] MODE_LINE        = 3'd4;
    localparam logic [2:0] MODE_BLOCK_OPEN  = 3'd5;
    localparam logic [2:0] MODE_BLOCK       = 3'd6;
    localparam logic [2:0] MODE_BLOCK_CLOSE = 3'd7;

    localparam logic [2:0] CLS_SKIP   = 3'd0;
    localparam logic [2:0] CLS_IDENT  = 3'd1;
    localparam logic [2:0] CLS_STRING = 3'd2;
    localparam logic [2:0] CLS_QUOTE  = 3'd3;
    localparam logic [2:0] CLS_NUMBER = 3'd4;
    localparam logic [2:0] CLS_MARK   = 3'd5;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_COMMENT = 2'd1;
    localparam logic [1:0] ERR_STRING  = 2'd2;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    typedef struct packed {
        logic [7:0] tagged_byte;
        logic [2:0] byte_class;
        logic       token_begins;
        logic       end_of_source;
        logic [1:0] lex_error;
    } result_t;

    typedef struct packed {
        logic [2:0] next_mode;
        logic [2:0] cls;
        logic       beg;
    } lex_step_t;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic number_part(input logic [7:0] c);
        return is_digit(c) || c == CH_DOT || c == CH_LOW_E || c == CH_UP_E
            || c == CH_PLUS || c == CH_MINUS;
    endfunction

    // One lexer step: class, token start and mode after byte b.
    function automatic lex_step_t lex_classify(input logic [2:0] mode,
                                               input logic [7:0] b,
                                               input logic       la_ok,
                                               input logic [7:0] la);
        lex_step_t r;
        logic      fresh;
        r.cls       = CLS_SKIP;
        r.beg       = 1'b0;
        r.next_mode = mode;
        fresh       = 1'b0;
        case (mode)
            MODE_IDENT:
            begin
                if (is_alpha(b) || is_digit(b) || b == CH_UNDER)
                    r.cls = CLS_IDENT;
                else
                    fresh = 1'b1;
            end
            MODE_NUMBER:
            begin
                if (number_part(b))
                    r.cls = CLS_NUMBER;
                else
                    fresh = 1'b1;
            end
            MODE_STRING:
            begin
                if (b == CH_QUOTE)
                begin
                    r.cls       = CLS_QUOTE;
                    r.next_mode = MODE_IDLE;
                end
                else
                    r.cls = CLS_STRING;
            end
            MODE_LINE:
            begin
                if (b == CH_LF)
                    r.next_mode = MODE_IDLE;
            end
            MODE_BLOCK_OPEN:
            begin
                r.next_mode = MODE_BLOCK;
            end
            MODE_BLOCK:
            begin
                if (b == CH_STAR && la_ok && la == CH_SLASH)
                    r.next_mode = MODE_BLOCK_CLOSE;
            end
            MODE_BLOCK_CLOSE:
            begin
                r.next_mode = MODE_IDLE;
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase
        if (fresh)
        begin
            r.next_mode = MODE_IDLE;
            if (is_space(b))
                r.cls = CLS_SKIP;
            else if (b == CH_SLASH && la_ok && la == CH_SLASH)
                r.next_mode = MODE_LINE;
            else if (b == CH_SLASH && la_ok && la == CH_STAR)
                r.next_mode = MODE_BLOCK_OPEN;
            else
            begin
                r.beg = 1'b1;
                if (is_alpha(b) || b == CH_UNDER)
                begin
                    r.cls       = CLS_IDENT;
                    r.next_mode = MODE_IDENT;
                end
                else if (b == CH_QUOTE)
                begin
                    r.cls       = CLS_QUOTE;
                    r.next_mode = MODE_STRING;
                end
                else if (is_digit(b) || b == CH_DOT
                         || ((b == CH_MINUS || b == CH_PLUS) && la_ok
                             && (is_digit(la) || la == CH_DOT)))
                begin
                    r.cls       = CLS_NUMBER;
                    r.next_mode = MODE_NUMBER;
                end
                else
                    r.cls = CLS_MARK;
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/ssl_src_if.sv =====
// Source byte channel of the script source lexer.
// No dependencies.
interface ssl_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       final_byte;

    modport source (output valid, output source_byte, output final_byte, input ready);
    modport sink   (input valid, input source_byte, input final_byte, output ready);
endinterface

// ===== hw/rtl/ssl_res_if.sv =====
// Result channel of the script source lexer: one tagged byte per beat.
// No dependencies.
interface ssl_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] tagged_byte;
    logic [2:0] byte_class;
    logic       token_begins;
    logic       end_of_source;
    logic [1:0] lex_error;

    modport source (output valid, output tagged_byte, output byte_class,
                    output token_begins, output end_of_source, output lex_error,
                    input ready);
    modport sink   (input valid, input tagged_byte, input byte_class,
                    input token_begins, input end_of_source, input lex_error,
                    output ready);
endinterface

// ===== hw/rtl/script_source_lexer_core.sv =====
// Script source lexer: takes one source byte per beat and returns one tagged byte
// per beat. Each byte is held until the next one arrives as lookahead, so its
// result leaves one input beat later; the final byte flushes the held byte and
// itself, two results from one beat. Results wait in a three-entry output queue;
// a byte is taken whenever the queue holds at most one result, independent of
// the result side's ready. Sustained rate is one byte per cycle while results
// are taken every cycle; after a final byte that flushes a held byte, input
// pauses while the queue drains back to one entry. lex_error is valid on the
// end_of_source result. Depends on ssl_pkg, ssl_src_if, ssl_res_if and the
// assertion macros.
`include "script_source_lexer_core_macros.svh"

module script_source_lexer_core (
    input  logic       clk,
    input  logic       rst_n,
    ssl_src_if.sink    src,
    ssl_res_if.source  res
);
    import ssl_pkg::*;

    logic [7:0] pending_byte_reg,  pending_byte_next;
    logic       pending_valid_reg, pending_valid_next;
    logic [2:0] mode_reg,          mode_next;
    logic [1:0] count_reg,         count_next;
    result_t    q_reg  [3];
    result_t    q_next [3];
    result_t    shifted [3];

    logic       accept;
    logic       pop;
    lex_step_t  step_held;
    lex_step_t  step_last;
    logic [2:0] mode_mid;
    result_t    res_held;
    result_t    res_last;
    result_t    push0;
    logic [1:0] n_push;
    logic [1:0] base;
    logic [1:0] err_last;

    assign accept = src.valid && src.ready;
    assign pop    = res.valid && res.ready;

    assign src.ready         = count_reg <= 2'd1;
    assign res.valid         = count_reg != 2'd0;
    assign res.tagged_byte   = q_reg[0].tagged_byte;
    assign res.byte_class    = q_reg[0].byte_class;
    assign res.token_begins  = q_reg[0].token_begins;
    assign res.end_of_source = q_reg[0].end_of_source;
    assign res.lex_error     = q_reg[0].lex_error;

    always_comb
    begin
        step_held = lex_classify(mode_reg, pending_byte_reg, 1'b1, src.source_byte);
        mode_mid  = pending_valid_reg ? step_held.next_mode : mode_reg;
        step_last = lex_classify(mode_mid, src.source_byte, 1'b0, 8'h00);

        case (step_last.next_mode)
            MODE_BLOCK, MODE_BLOCK_OPEN, MODE_BLOCK_CLOSE: err_last = ERR_COMMENT;
            MODE_STRING:                                   err_last = ERR_STRING;
            default:                                       err_last = ERR_NONE;
        endcase

        res_held.tagged_byte   = pending_byte_reg;
        res_held.byte_class    = step_held.cls;
        res_held.token_begins  = step_held.beg;
        res_held.end_of_source = 1'b0;
        res_held.lex_error     = ERR_NONE;

        res_last.tagged_byte   = src.source_byte;
        res_last.byte_class    = step_last.cls;
        res_last.token_begins  = step_last.beg;
        res_last.end_of_source = 1'b1;
        res_last.lex_error     = err_last;

        push0  = pending_valid_reg ? res_held : res_last;
        n_push = accept ? ({1'b0, pending_valid_reg} + {1'b0, src.final_byte}) : 2'd0;

        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;
        mode_next          = mode_reg;
        if (accept)
        begin
            if (src.final_byte)
            begin
                pending_byte_next  = 8'h00;
                pending_valid_next = 1'b0;
                mode_next          = MODE_IDLE;
            end
            else
            begin
                pending_byte_next  = src.source_byte;
                pending_valid_next = 1'b1;
                mode_next          = mode_mid;
            end
        end
    end

    // Output queue: head at slot 0, shift on pop, append behind the survivors.
    always_comb
    begin
        shifted[0] = pop ? q_reg[1] : q_reg[0];
        shifted[1] = pop ? q_reg[2] : q_reg[1];
        shifted[2] = q_reg[2];
        base       = count_reg - {1'b0, pop};
        for (int i = 0; i < 3; i++)
        begin
            q_next[i] = shifted[i];
            if (n_push != 2'd0 && 2'(i) == base)
                q_next[i] = push0;
            if (n_push == 2'd2 && 2'(i) == 2'(base + 2'd1))
                q_next[i] = res_last;
        end
        count_next = count_reg - {1'b0, pop} + n_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_byte_reg  <= 8'h00;
            pending_valid_reg <= 1'b0;
            mode_reg          <= MODE_IDLE;
            count_reg         <= 2'd0;
        end
        else
        begin
            pending_byte_reg  <= pending_byte_next;
            pending_valid_reg <= pending_valid_next;
            mode_reg          <= mode_next;
            count_reg         <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            q_reg[i] <= q_next[i];
    end

    `SSL_ASSERT_NEXT(a_final_flushes, accept && src.final_byte,
        !pending_valid_reg && mode_reg == MODE_IDLE, "final byte left lexer state behind")
    `SSL_ASSERT_NOW(a_err_only_at_end, res.valid && res.lex_error != ERR_NONE,
        res.end_of_source, "lex_error set on a non-final result")
    `SSL_ASSERT_NOW(a_begin_class, res.valid && res.token_begins,
        res.byte_class == CLS_IDENT || res.byte_class == CLS_QUOTE
        || res.byte_class == CLS_NUMBER || res.byte_class == CLS_MARK,
        "token start on a skipped or string byte")
    `SSL_ASSERT_NOW(a_no_overflow, accept,
        count_reg + n_push <= 2'd3 && count_reg <= 2'd1, "output queue overrun")

endmodule
